@@ src/coapv_pkg.sv @@
package coapv_pkg;

  localparam int COUNT_BITS_DEF = 17;
  localparam int LEN_W = 17;
  localparam logic [15:0] MAX_SIZE_RESET = 16'd1152;

  localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0] NIBBLE_RESERVED = 4'hF;
  localparam logic [3:0] NIBBLE_EXT1 = 4'd13;
  localparam logic [3:0] NIBBLE_EXT2 = 4'd14;
  localparam logic [3:0] EXT_BIAS = 4'd12;
  localparam logic [LEN_W-1:0] EXT1_BASE = LEN_W'(13);
  localparam logic [LEN_W-1:0] EXT2_BASE = LEN_W'(269);
  localparam logic [3:0] TOKEN_NIB_MAX = 4'd8;
  localparam logic [1:0] PROTO_VER = 2'd1;

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_TOKEN   = 8'b0000_0010,
    PH_OPT     = 8'b0000_0100,
    PH_DEXT    = 8'b0000_1000,
    PH_LEXT    = 8'b0001_0000,
    PH_VALUE   = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_HALT    = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    OPT_NONE    = 2'd0,
    OPT_BAD_NIB = 2'd1,
    OPT_OVERRUN = 2'd2
  } opt_err_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_SMALL       = 3'd1,
    ERR_VERSION     = 3'd2,
    ERR_LARGE       = 3'd3,
    ERR_TOKEN       = 3'd4,
    ERR_EMPTY_EXTRA = 3'd5,
    ERR_BAD_NIBBLE  = 3'd6,
    ERR_OVERRUN     = 3'd7
  } err_code_t;

  typedef struct packed {
    logic       bad_version;
    logic       empty_code;
    logic [3:0] tok_nib;
    opt_err_t   opt_err;
  } coapv_status_t;

endpackage

@@ src/coapv_if.sv @@
interface coapv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface coapv_out_if;
  logic       valid;
  logic       ready;
  logic       message_valid;
  logic [2:0] error_code;

  modport source(output valid, output message_valid, output error_code, input ready);
  modport sink(input valid, input message_valid, input error_code, output ready);
endinterface

@@ src/coapv_parser.sv @@
module coapv_parser import coapv_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic [COUNT_BITS-1:0] size_nxt,
  output coapv_status_t         stat
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int WIDE = (COUNT_BITS > LEN_W ? COUNT_BITS : LEN_W) + 1;

  logic [COUNT_BITS-1:0] byte_count_r, byte_count_nxt;
  phase_t                phase_r, phase_nxt;
  logic [3:0]            tok_nib_r, tok_nib_nxt;
  logic [1:0]            flags_r, flags_nxt;
  logic [3:0]            pend_nib_r, pend_nib_nxt;
  logic [7:0]            ext_hold_r, ext_hold_nxt;
  logic [COUNT_BITS-1:0] skip_r, skip_nxt;
  opt_err_t              opt_err_r, opt_err_nxt;

  logic [COUNT_BITS-1:0] skip_dec;
  logic [LEN_W-1:0]      ext_len;
  logic [WIDE-1:0]       ext_len_w;
  logic [3:0]            nib_d, nib_l, len_nib;
  opt_err_t              opt_err_fin;

  assign skip_dec = (skip_r != '0) ? skip_r - COUNT_BITS'(1) : '0;
  assign nib_d = data_byte[7:4];
  assign nib_l = data_byte[3:0];

  always_comb begin
    if (pend_nib_r == NIBBLE_EXT1) begin
      ext_len = EXT1_BASE + LEN_W'(data_byte);
    end else begin
      ext_len = EXT2_BASE + LEN_W'({ext_hold_r, data_byte});
    end
    ext_len_w = WIDE'(ext_len);
  end

  always_comb begin
    byte_count_nxt = (byte_count_r == COUNT_MAX) ? COUNT_MAX : byte_count_r + COUNT_BITS'(1);
    phase_nxt      = phase_r;
    tok_nib_nxt    = tok_nib_r;
    flags_nxt      = flags_r;
    pend_nib_nxt   = pend_nib_r;
    ext_hold_nxt   = ext_hold_r;
    skip_nxt       = skip_r;
    opt_err_nxt    = opt_err_r;
    len_nib        = pend_nib_r;
    case (phase_r)
      PH_HEADER: begin
        if (byte_count_r == '0) begin
          if (data_byte[7:6] != PROTO_VER) flags_nxt[0] = 1'b1;
          tok_nib_nxt = data_byte[3:0];
        end else if (byte_count_r == COUNT_BITS'(1)) begin
          if (data_byte == 8'd0) flags_nxt[1] = 1'b1;
        end else if (byte_count_r >= COUNT_BITS'(3)) begin
          if (tok_nib_r == 4'd0) begin
            phase_nxt = PH_OPT;
          end else begin
            skip_nxt  = COUNT_BITS'(tok_nib_r);
            phase_nxt = PH_TOKEN;
          end
        end
      end
      PH_TOKEN, PH_VALUE: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) phase_nxt = PH_OPT;
      end
      PH_OPT: begin
        if (data_byte == PAYLOAD_MARKER) begin
          phase_nxt = PH_PAYLOAD;
        end else if (nib_d == NIBBLE_RESERVED || nib_l == NIBBLE_RESERVED) begin
          opt_err_nxt = OPT_BAD_NIB;
          phase_nxt   = PH_HALT;
        end else begin
          pend_nib_nxt = nib_l;
          len_nib      = nib_l;
          if (nib_d >= NIBBLE_EXT1) begin
            skip_nxt  = COUNT_BITS'(nib_d - EXT_BIAS);
            phase_nxt = PH_DEXT;
          end else if (len_nib >= NIBBLE_EXT1) begin
            skip_nxt  = COUNT_BITS'(len_nib - EXT_BIAS);
            phase_nxt = PH_LEXT;
          end else if (len_nib == 4'd0) begin
            phase_nxt = PH_OPT;
          end else begin
            skip_nxt  = COUNT_BITS'(len_nib);
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_DEXT: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          if (len_nib >= NIBBLE_EXT1) begin
            skip_nxt  = COUNT_BITS'(len_nib - EXT_BIAS);
            phase_nxt = PH_LEXT;
          end else if (len_nib == 4'd0) begin
            phase_nxt = PH_OPT;
          end else begin
            skip_nxt  = COUNT_BITS'(len_nib);
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_LEXT: begin
        if (skip_r >= COUNT_BITS'(2)) begin
          ext_hold_nxt = data_byte;
          skip_nxt     = COUNT_BITS'(1);
        end else begin
          // Extended lengths reach 65804, which can exceed the counter.
          if (ext_len_w > WIDE'(COUNT_MAX)) begin
            skip_nxt = COUNT_MAX;
          end else begin
            skip_nxt = ext_len_w[COUNT_BITS-1:0];
          end
          phase_nxt = PH_VALUE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    opt_err_fin = opt_err_nxt;
    if (opt_err_nxt == OPT_NONE &&
        (phase_nxt == PH_TOKEN || phase_nxt == PH_DEXT ||
         phase_nxt == PH_LEXT || phase_nxt == PH_VALUE)) begin
      opt_err_fin = OPT_OVERRUN;
    end
  end

  assign size_nxt         = byte_count_nxt;
  assign stat.bad_version = flags_nxt[0];
  assign stat.empty_code  = flags_nxt[1];
  assign stat.tok_nib     = tok_nib_nxt;
  assign stat.opt_err     = opt_err_fin;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      byte_count_r <= '0;
      phase_r      <= PH_HEADER;
      tok_nib_r    <= '0;
      flags_r      <= '0;
      pend_nib_r   <= '0;
      ext_hold_r   <= '0;
      skip_r       <= '0;
      opt_err_r    <= OPT_NONE;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      phase_r      <= phase_nxt;
      tok_nib_r    <= tok_nib_nxt;
      flags_r      <= flags_nxt;
      pend_nib_r   <= pend_nib_nxt;
      ext_hold_r   <= ext_hold_nxt;
      skip_r       <= skip_nxt;
      opt_err_r    <= opt_err_nxt;
    end
  end

endmodule

@@ src/coap_message_verifier.sv @@
// CoAP message verifier: bytes of one message enter on in_chan in wire order, one per cycle,
// with last_byte set on the final byte; for each message one verdict (message_valid and an
// error_code, lowest failing check first) leaves on out_chan in the cycle after that final byte
// transfer. The block takes one byte in every cycle; the only pause comes from a verdict
// still held in the output register while out_chan stalls. The user sets max_message_size
// by cfg_we/cfg_wdata between messages; the block does not enforce it. Resets to 1152.
module coap_message_verifier import coapv_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  coapv_in_if.sink    in_chan,
  coapv_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int WIDE = (COUNT_BITS > 16 ? COUNT_BITS : 16) + 1;

  logic [15:0]           max_size_r;
  logic                  out_valid_r;
  logic                  msg_ok_r;
  err_code_t             code_r;
  err_code_t             code_nxt;
  logic                  accept;
  logic [COUNT_BITS-1:0] size_nxt;
  logic [WIDE-1:0]       size_w;
  coapv_status_t         stat;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  coapv_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_chan.data_byte),
    .last_byte (in_chan.last_byte),
    .size_nxt  (size_nxt),
    .stat      (stat)
  );

  assign size_w = WIDE'(size_nxt);

  always_comb begin
    if (size_w < WIDE'(4)) begin
      code_nxt = ERR_SMALL;
    end else if (stat.bad_version) begin
      code_nxt = ERR_VERSION;
    end else if (size_w > WIDE'(max_size_r)) begin
      code_nxt = ERR_LARGE;
    end else if (stat.tok_nib > TOKEN_NIB_MAX) begin
      code_nxt = ERR_TOKEN;
    end else if (stat.empty_code && size_w != WIDE'(4)) begin
      code_nxt = ERR_EMPTY_EXTRA;
    end else if (stat.opt_err == OPT_BAD_NIB) begin
      code_nxt = ERR_BAD_NIBBLE;
    end else if (stat.opt_err == OPT_OVERRUN) begin
      code_nxt = ERR_OVERRUN;
    end else begin
      code_nxt = ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RESET;
    end else if (cfg_we) begin
      max_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_chan.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.last_byte) begin
      code_r   <= code_nxt;
      msg_ok_r <= (code_nxt == ERR_OK);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.message_valid = msg_ok_r;
  assign out_chan.error_code    = code_r;

endmodule
